>>> rtl/bct_pkg.sv
// ---------------------------------------------------------------------------
// bct_pkg: shared types and constants of the Bezier curve tessellator
// Point type, sequencer states and fixed widths of the datapath.
// ---------------------------------------------------------------------------
`default_nettype none
package bct_pkg;

  localparam int COORD_W = 32;
  localparam int T_W     = 17;   // unsigned Q1.16
  localparam int SEG_W   = 7;    // segment count and index
  localparam int NUM_W   = 23;   // index * 65536 + half divisor
  localparam int REM_W   = 8;
  localparam int DCNT_W  = 5;

  typedef struct packed {
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } pt_t;

  typedef struct packed {
    logic copy;   // working point <= stored point
    logic step;   // working point <= lerp(own, neighbor, t)
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVST,
    ST_DIV,
    ST_LOAD,
    ST_ROUND,
    ST_CAPT
  } state_t;

endpackage
`default_nettype wire

>>> rtl/bezier_curve_tessellator_top.sv
// ---------------------------------------------------------------------------
// bezier_curve_tessellator_top: Bezier curve to line segment tessellator
// Collects control points and emits line segments along the curve.
// ---------------------------------------------------------------------------
// Control points arrive one per beat on the in_ channel (x, y, z in tdata,
// tlast closes the curve). Beats are taken only while the block is idle.
// When the closing point is taken, in_tready drops and the sequencer walks the
// curve: for each curve point a bit-serial divider forms t, the cell row
// copies the stored points and runs n-1 interpolation rounds in which every
// cell moves toward its right neighbor's point, then cell 0 holds the curve
// point. The curve start takes one extra such pass before the first segment.
// Two points give one straight segment.
// Segments leave on the out_ channel through an output register; when the
// receiver stalls, the next curve point is still computed and the sequencer
// holds it until the register frees. in_tready rises again after the final
// segment is loaded. cfg_wr_en writes the segment count (reset 16).
// rst_n is synchronous: it empties the point store and the output register.
// ---------------------------------------------------------------------------
`default_nettype none
module bezier_curve_tessellator_top #(
  parameter int MAX_POINTS   = 16,
  parameter int MAX_SEGMENTS = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [95:0]   in_tdata,   // point_x, point_y, point_z
  input  wire logic          in_tlast,   // last_point
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [191:0]       out_tdata,  // start_x, start_y, start_z, end_x, end_y, end_z
  output logic               out_tlast,  // last_segment
  input  wire logic          cfg_wr_en,
  input  wire logic [6:0]    cfg_wr_data
);

  localparam int PTR_W = $clog2(MAX_POINTS + 1);

  bct_pkg::state_t            state_r, state_nxt;
  logic [PTR_W-1:0]           held_r, held_nxt;
  logic [PTR_W-1:0]           n_r, n_nxt;
  logic [PTR_W-1:0]           round_r, round_nxt;
  logic [PTR_W-1:0]           n_new;
  logic [bct_pkg::SEG_W-1:0]  cfg_segs_r;
  logic [bct_pkg::SEG_W-1:0]  segs_r, segs_nxt, segs_new;
  logic [bct_pkg::SEG_W-1:0]  seg_i_r, seg_i_nxt;
  logic [bct_pkg::T_W-1:0]    t_r, t_nxt;
  bct_pkg::pt_t               prev_r, prev_nxt;
  bct_pkg::pt_t               in_pt;
  logic                       in_acc;
  logic                       out_valid_r, out_valid_nxt;
  logic [191:0]               out_data_r, out_data_nxt;
  logic                       out_last_r, out_last_nxt;
  bct_pkg::cell_ctl_t         ctl;
  logic                       div_start;
  logic                       div_done;
  logic [bct_pkg::T_W-1:0]    div_q;
  logic [bct_pkg::NUM_W-1:0]  div_num;
  bct_pkg::pt_t               w [MAX_POINTS];

  assign in_pt  = in_tdata;
  assign in_acc = in_tvalid && in_tready;
  assign in_tready = (state_r == bct_pkg::ST_IDLE);

  assign n_new = (held_r < PTR_W'(MAX_POINTS)) ? held_r + 1'b1 : held_r;
  always_comb begin
    if (n_new == PTR_W'(2)) begin
      segs_new = bct_pkg::SEG_W'(1);
    end else if (cfg_segs_r > bct_pkg::SEG_W'(MAX_SEGMENTS)) begin
      segs_new = bct_pkg::SEG_W'(MAX_SEGMENTS);
    end else begin
      segs_new = cfg_segs_r;
    end
  end

  assign div_num = {seg_i_r, 16'h0000} + bct_pkg::NUM_W'(segs_r >> 1);

  genvar gi;
  generate
    for (gi = 0; gi < MAX_POINTS; gi++) begin : g_cell
      bct_cell u_cell (
        .clk   (clk),
        .wr_en (in_acc && (held_r == PTR_W'(gi))),
        .wr_pt (in_pt),
        .ctl   (ctl),
        .t     (t_r),
        .nbr_w (w[(gi < MAX_POINTS - 1) ? gi + 1 : gi]),
        .w     (w[gi])
      );
    end
  endgenerate

  bct_tdiv u_tdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (segs_r),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    n_nxt         = n_r;
    round_nxt     = round_r;
    segs_nxt      = segs_r;
    seg_i_nxt     = seg_i_r;
    t_nxt         = t_r;
    prev_nxt      = prev_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    ctl           = '0;
    div_start     = 1'b0;
    case (state_r)
      bct_pkg::ST_IDLE: begin
        if (in_acc) begin
          held_nxt = n_new;
          if (in_tlast) begin
            held_nxt  = '0;
            n_nxt     = n_new;
            segs_nxt  = segs_new;
            seg_i_nxt = '0;
            if (n_new >= PTR_W'(2) && segs_new != '0) begin
              state_nxt = bct_pkg::ST_DIVST;
            end
          end
        end
      end
      bct_pkg::ST_DIVST: begin
        div_start = 1'b1;
        state_nxt = bct_pkg::ST_DIV;
      end
      bct_pkg::ST_DIV: begin
        if (div_done) begin
          t_nxt     = div_q;
          state_nxt = bct_pkg::ST_LOAD;
        end
      end
      bct_pkg::ST_LOAD: begin
        ctl.copy  = 1'b1;
        round_nxt = PTR_W'(1);
        state_nxt = bct_pkg::ST_ROUND;
      end
      bct_pkg::ST_ROUND: begin
        ctl.step  = 1'b1;
        round_nxt = round_r + 1'b1;
        if (round_r == n_r - 1'b1) begin
          state_nxt = bct_pkg::ST_CAPT;
        end
      end
      bct_pkg::ST_CAPT: begin
        if (seg_i_r == '0) begin
          prev_nxt  = w[0];
          seg_i_nxt = bct_pkg::SEG_W'(1);
          state_nxt = bct_pkg::ST_DIVST;
        end else if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {w[0], prev_r};
          out_last_nxt  = (seg_i_r == segs_r);
          prev_nxt      = w[0];
          seg_i_nxt     = seg_i_r + 1'b1;
          state_nxt     = (seg_i_r == segs_r) ? bct_pkg::ST_IDLE : bct_pkg::ST_DIVST;
        end
      end
      default: begin
        state_nxt = bct_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bct_pkg::ST_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
      cfg_segs_r  <= bct_pkg::SEG_W'(16);
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_segs_r <= cfg_wr_data;
      end
    end
    n_r        <= n_nxt;
    round_r    <= round_nxt;
    segs_r     <= segs_nxt;
    seg_i_r    <= seg_i_nxt;
    t_r        <= t_nxt;
    prev_r     <= prev_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= PTR_W'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bct_pkg::ST_ROUND) |-> (round_r < n_r))
    else $error("interpolation round beyond point count");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast && n_new >= PTR_W'(2) && segs_new != '0) |=> !in_tready)
    else $error("input taken while curve in progress");

endmodule
`default_nettype wire

>>> rtl/bct_cell.sv
// ---------------------------------------------------------------------------
// bct_cell: one control point cell of the De Casteljau row
// Holds one stored point and one working point; a step replaces the working
// point by the interpolation toward the right neighbor's working point.
// ---------------------------------------------------------------------------
`default_nettype none
module bct_cell (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire bct_pkg::pt_t             wr_pt,
  input  wire bct_pkg::cell_ctl_t       ctl,
  input  wire logic [bct_pkg::T_W-1:0]  t,
  input  wire bct_pkg::pt_t             nbr_w,
  output bct_pkg::pt_t                  w
);

  bct_pkg::pt_t p_r;
  bct_pkg::pt_t w_r;
  bct_pkg::pt_t w_nxt;

  function automatic logic [31:0] lerp(input logic [31:0] a, input logic [31:0] b,
                                       input logic [bct_pkg::T_W-1:0] tt);
    logic signed [32:0] diff;
    logic signed [50:0] prod;
    logic signed [50:0] rnd;
    logic signed [35:0] sh;
    logic signed [35:0] res;
    diff = $signed({b[31], b}) - $signed({a[31], a});
    prod = diff * $signed({1'b0, tt});
    rnd  = prod + 51'sd32768;
    sh   = 36'(rnd >>> 16);
    res  = $signed({{4{a[31]}}, a}) + sh;
    if (res > 36'sd2147483647) begin
      lerp = 32'h7FFF_FFFF;
    end else if (res < -36'sd2147483648) begin
      lerp = 32'h8000_0000;
    end else begin
      lerp = res[31:0];
    end
  endfunction

  always_comb begin
    w_nxt = w_r;
    if (ctl.copy) begin
      w_nxt = p_r;
    end else if (ctl.step) begin
      w_nxt.x = lerp(w_r.x, nbr_w.x, t);
      w_nxt.y = lerp(w_r.y, nbr_w.y, t);
      w_nxt.z = lerp(w_r.z, nbr_w.z, t);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      p_r <= wr_pt;
    end
    w_r <= w_nxt;
  end

  assign w = w_r;

endmodule
`default_nettype wire

>>> rtl/bct_tdiv.sv
// ---------------------------------------------------------------------------
// bct_tdiv: curve parameter divider
// Restoring division, one quotient bit per cycle, for t = num / den.
// ---------------------------------------------------------------------------
`default_nettype none
module bct_tdiv (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [bct_pkg::NUM_W-1:0]     num,
  input  wire logic [bct_pkg::SEG_W-1:0]     den,
  output logic                               done,
  output logic [bct_pkg::T_W-1:0]            quot
);

  logic [bct_pkg::NUM_W-1:0]  q_r, q_nxt;
  logic [bct_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [bct_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [bct_pkg::REM_W-1:0]  rem_sh;
  logic [bct_pkg::REM_W-1:0]  den_x;

  assign den_x = {1'b0, den};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[bct_pkg::REM_W-2:0], q_r[bct_pkg::NUM_W-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= den_x) begin
        rem_nxt = rem_sh - den_x;
        q_nxt   = {q_r[bct_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[bct_pkg::NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == bct_pkg::DCNT_W'(bct_pkg::NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = q_r[bct_pkg::T_W-1:0];

endmodule
`default_nettype wire
